[hdl/polyphonic_voice_allocator_defines.svh]
// assertion helpers used by the pva_back module
`ifndef POLYPHONIC_VOICE_ALLOCATOR_DEFINES_SVH
`define POLYPHONIC_VOICE_ALLOCATOR_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define PVA_ASSERT_NOW(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("voice allocator check failed");

// condition holds in the cycle after the trigger
`define PVA_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("voice allocator check failed");

`endif

[hdl/pva_pkg.sv]
`timescale 1ns / 1ps
package pva_pkg;

  localparam int VOICES     = 64;
  localparam int NOTE_COUNT = 120;
  localparam int VIDX_W     = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int NOTE_W     = 7;
  localparam int QDEPTH     = 2;

  // register byte address bit that selects the register
  localparam logic REG_INSTRUMENT = 1'b0;

  typedef enum logic [1:0] {
    OP_PRESS   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_STOP    = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    BE_IDLE,
    BE_REL,
    BE_STOP
  } be_state_t;

  typedef struct packed {
    op_t                op;
    logic [NOTE_W-1:0]  note;
    logic [7:0]         velocity;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  // index of the lowest set bit, 0 when none is set
  function automatic logic [VIDX_W-1:0] lowest_set(input logic [VOICES-1:0] v);
    logic [VOICES-1:0] iso;
    logic [VIDX_W-1:0] idx;
    iso = v & (~v + {{(VOICES-1){1'b0}}, 1'b1});
    idx = '0;
    for (int j = 0; j < VOICES; j++) begin
      if (iso[j]) begin
        idx = idx | VIDX_W'(j);
      end
    end
    return idx;
  endfunction

  function automatic logic [VOICES-1:0] reverse(input logic [VOICES-1:0] v);
    logic [VOICES-1:0] r;
    for (int j = 0; j < VOICES; j++) begin
      r[j] = v[VOICES-1-j];
    end
    return r;
  endfunction

endpackage

[hdl/pva_ifs.sv]
`timescale 1ns / 1ps
interface pva_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] note;
  logic [7:0] velocity;
  modport source(output valid, op, note, velocity, input ready);
  modport sink(input valid, op, note, velocity, output ready);
endinterface

interface pva_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] channel;
  logic       note_off;
  logic [6:0] note_code;
  logic [7:0] volume;
  logic [7:0] instrument;
  logic       last;
  modport source(output valid, channel, note_off, note_code, volume, instrument, last,
                 input ready);
  modport sink(input valid, channel, note_off, note_code, volume, instrument, last,
               output ready);
endinterface

[hdl/pva_ram.sv]
`timescale 1ns / 1ps
module pva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/pva_front.sv]
`timescale 1ns / 1ps
module pva_front (
  input  logic             clk,
  input  logic             rst_n,
  pva_in_if.sink           in_if,
  input  logic             pop,
  output pva_pkg::q_head_t head
);

  pva_pkg::cmd_t q_mem_r [pva_pkg::QDEPTH];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;
  logic          keep;
  logic          push;
  logic          do_pop;
  pva_pkg::cmd_t in_cmd;

  // drop out-of-range notes and the unused op code here
  always_comb begin
    case (in_if.op)
      pva_pkg::OP_PRESS,
      pva_pkg::OP_RELEASE: keep = (in_if.note < 8'(pva_pkg::NOTE_COUNT));
      pva_pkg::OP_STOP:    keep = 1'b1;
      default:             keep = 1'b0;
    endcase
  end

  assign in_cmd.op       = pva_pkg::op_t'(in_if.op);
  assign in_cmd.note     = in_if.note[pva_pkg::NOTE_W-1:0];
  assign in_cmd.velocity = in_if.velocity;

  assign in_if.ready = (count_r != 2'(pva_pkg::QDEPTH));
  assign push        = in_if.valid && in_if.ready && keep;
  assign do_pop      = pop && (count_r != 2'd0);

  always_comb begin
    wr_ptr_nxt = push   ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= in_cmd;
    end
  end

  assign head.valid = (count_r != 2'd0);
  assign head.cmd   = q_mem_r[rd_ptr_r];

endmodule

[hdl/pva_back.sv]
`timescale 1ns / 1ps
`include "polyphonic_voice_allocator_defines.svh"
module pva_back (
  input  logic             clk,
  input  logic             rst_n,
  input  pva_pkg::q_head_t head,
  output logic             pop,
  input  logic [7:0]       instrument,
  pva_out_if.source        out_if
);

  localparam int VW = pva_pkg::VIDX_W;
  localparam int NW = pva_pkg::NOTE_W;

  pva_pkg::be_state_t         state_r, state_nxt;
  logic [pva_pkg::VOICES-1:0] busy_r, busy_nxt;
  logic [VW-1:0]              idx_r, idx_nxt;
  logic [NW-1:0]              note_r, note_nxt;

  logic       out_valid_r;
  logic [5:0] out_channel_r;
  logic       out_note_off_r;
  logic [6:0] out_note_code_r;
  logic [7:0] out_volume_r;
  logic [7:0] out_instrument_r;
  logic       out_last_r;

  logic       load;
  logic [5:0] ld_channel;
  logic       ld_note_off;
  logic [6:0] ld_note_code;
  logic [7:0] ld_volume;
  logic [7:0] ld_instrument;
  logic       ld_last;

  logic                       out_free;
  logic [pva_pkg::VOICES-1:0] free_v;
  logic [VW-1:0]              press_ch;
  logic [VW-1:0]              stop_ch;
  logic                       stop_last;
  logic                       rel_hit;
  logic                       start;

  logic          we;
  logic [VW-1:0] waddr;
  logic [NW-1:0] wdata;
  logic [VW-1:0] raddr;
  logic [NW-1:0] rdata;

  logic          press_go;
  logic          rel_done;
  logic          stop_done;
  logic          last_shown;
  logic          back_idle;

  pva_ram #(
    .WIDTH(NW),
    .DEPTH(pva_pkg::VOICES)
  ) u_note_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign out_free = !out_valid_r || out_if.ready;
  assign start    = head.valid && out_free && (state_r == pva_pkg::BE_IDLE);
  assign free_v   = ~busy_r;

  // highest free voice, or voice 0 when all are taken
  assign press_ch = (free_v == '0) ? '0 :
                    VW'(pva_pkg::VOICES-1) - pva_pkg::lowest_set(pva_pkg::reverse(free_v));

  // lower voices are already cleared, so this is the last one if nothing else is busy
  assign stop_ch   = pva_pkg::lowest_set(busy_r);
  assign stop_last = ((busy_r & ~({{(pva_pkg::VOICES-1){1'b0}}, 1'b1} << stop_ch)) == '0);

  // ram data belongs to idx_r while scanning
  assign rel_hit = busy_r[idx_r] && (rdata == note_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pva_pkg::BE_IDLE: begin
        if (start) begin
          case (head.cmd.op)
            pva_pkg::OP_RELEASE: state_nxt = pva_pkg::BE_REL;
            pva_pkg::OP_STOP:    state_nxt = pva_pkg::BE_STOP;
            default:             state_nxt = pva_pkg::BE_IDLE;
          endcase
        end
      end
      pva_pkg::BE_REL: begin
        if (rel_hit) begin
          if (out_free) begin
            state_nxt = pva_pkg::BE_IDLE;
          end
        end else if (idx_r == '0) begin
          state_nxt = pva_pkg::BE_IDLE;
        end
      end
      pva_pkg::BE_STOP: begin
        if (busy_r == '0) begin
          state_nxt = pva_pkg::BE_IDLE;
        end else if (out_free && stop_last) begin
          state_nxt = pva_pkg::BE_IDLE;
        end
      end
      default: state_nxt = pva_pkg::BE_IDLE;
    endcase
  end

  always_comb begin
    pop           = 1'b0;
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    note_nxt      = note_r;
    we            = 1'b0;
    waddr         = press_ch;
    wdata         = head.cmd.note;
    raddr         = idx_r;
    load          = 1'b0;
    ld_channel    = '0;
    ld_note_off   = 1'b1;
    ld_note_code  = '0;
    ld_volume     = '0;
    ld_instrument = '0;
    ld_last       = 1'b1;
    case (state_r)
      pva_pkg::BE_IDLE: begin
        if (start) begin
          pop = 1'b1;
          case (head.cmd.op)
            pva_pkg::OP_PRESS: begin
              busy_nxt[press_ch] = 1'b1;
              we                 = 1'b1;
              load               = 1'b1;
              ld_channel         = 6'(press_ch);
              ld_note_off        = 1'b0;
              ld_note_code       = head.cmd.note;
              ld_volume          = head.cmd.velocity;
              ld_instrument      = instrument;
            end
            pva_pkg::OP_RELEASE: begin
              note_nxt = head.cmd.note;
              idx_nxt  = VW'(pva_pkg::VOICES-1);
              raddr    = VW'(pva_pkg::VOICES-1);
            end
            default: begin
            end
          endcase
        end
      end
      pva_pkg::BE_REL: begin
        if (rel_hit) begin
          if (out_free) begin
            busy_nxt[idx_r] = 1'b0;
            load            = 1'b1;
            ld_channel      = 6'(idx_r);
          end
        end else if (idx_r != '0) begin
          idx_nxt = idx_r - VW'(1);
          raddr   = idx_r - VW'(1);
        end
      end
      pva_pkg::BE_STOP: begin
        if ((busy_r != '0) && out_free) begin
          busy_nxt[stop_ch] = 1'b0;
          load              = 1'b1;
          ld_channel        = 6'(stop_ch);
          ld_last           = stop_last;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pva_pkg::BE_IDLE;
      busy_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    note_r <= note_nxt;
    if (load) begin
      out_channel_r    <= ld_channel;
      out_note_off_r   <= ld_note_off;
      out_note_code_r  <= ld_note_code;
      out_volume_r     <= ld_volume;
      out_instrument_r <= ld_instrument;
      out_last_r       <= ld_last;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.channel    = out_channel_r;
  assign out_if.note_off   = out_note_off_r;
  assign out_if.note_code  = out_note_code_r;
  assign out_if.volume     = out_volume_r;
  assign out_if.instrument = out_instrument_r;
  assign out_if.last       = out_last_r;

  assign press_go   = start && (head.cmd.op == pva_pkg::OP_PRESS);
  assign rel_done   = (state_r == pva_pkg::BE_REL) && rel_hit && out_free;
  assign stop_done  = (state_r == pva_pkg::BE_STOP) && load && stop_last;
  assign last_shown = out_valid_r && out_last_r;
  assign back_idle  = (state_r == pva_pkg::BE_IDLE);

  `PVA_ASSERT_NEXT(a_press_sets_busy, clk, rst_n, press_go, busy_r[$past(press_ch)])
  `PVA_ASSERT_NEXT(a_release_frees, clk, rst_n, rel_done, !busy_r[$past(idx_r)] && last_shown)
  `PVA_ASSERT_NEXT(a_stop_last_empty, clk, rst_n, stop_done, (busy_r == '0) && back_idle)
  `PVA_ASSERT_NOW(a_load_has_room, clk, rst_n, load, out_free)

endmodule

[hdl/polyphonic_voice_allocator.sv]
`timescale 1ns / 1ps
// Voice allocator for a polyphonic synth: key press, key release and stop-all
// items go into a two-entry command queue after out-of-range notes and the
// unused op code are dropped, and an executor works off the queue into a
// one-deep result register, so input and output stall independently. A key
// press takes the highest free voice. A key release scans the note RAM from the
// highest voice down, one entry per cycle through its registered read port,
// until it finds the note or has checked voice 0.
// Stop-all frees the busy voices one at a time, lowest first, and flags the last.
// Results are produced at most one per cycle, throttled by out ready.
// The instrument register sits at byte address 0 and is read back on prdata.
module polyphonic_voice_allocator (
  input  logic        clk,
  input  logic        rst_n,
  pva_in_if.sink      in_if,
  pva_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]       instrument_r, instrument_nxt;
  logic             pop;
  pva_pkg::q_head_t head;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == pva_pkg::REG_INSTRUMENT);

  always_comb begin
    instrument_nxt = cfg_wr ? pwdata[7:0] : instrument_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      instrument_r <= 8'd0;
    end else begin
      instrument_r <= instrument_nxt;
    end
  end

  assign prdata = (paddr[2] == pva_pkg::REG_INSTRUMENT) ? {24'd0, instrument_r} : 32'd0;

  pva_front u_front (
    .clk  (clk),
    .rst_n(rst_n),
    .in_if(in_if),
    .pop  (pop),
    .head (head)
  );

  pva_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .instrument(instrument_r),
    .out_if    (out_if)
  );

endmodule
